// ===== rtl/chained_hash_table_engine_macros.svh =====
// ----------------------------------------------------------------------------
// chained_hash_table_engine_macros.svh
// Assertion macros shared by the hash table engine RTL.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// Sizes, operation codes, sequencer states and hash step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

  localparam int BUCKETS  = 64;
  localparam int NODES    = 256;
  localparam int KEY_BITS = 8;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 8;
  localparam int NID_W  = 8;
  localparam int RES_W  = 8;
  localparam int HASH_W = 32;

  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NODE_W = $clog2(NODES);
  localparam int LINK_W = NODE_W + 1;
  localparam int STEP_W = NODE_W + 1;
  localparam int KCNT_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  // Shift amounts of the one-at-a-time hash.
  localparam int SH_MIX_L = 10;
  localparam int SH_MIX_R = 6;
  localparam int SH_FIN_A = 3;
  localparam int SH_FIN_B = 11;
  localparam int SH_FIN_C = 15;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HASH = 8'b0000_0010,
    S_FIN  = 8'b0000_0100,
    S_HEAD = 8'b0000_1000,
    S_INS  = 8'b0001_0000,
    S_WALK = 8'b0010_0000,
    S_CMP  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  // One key bit folded into the running hash.
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic b);
    logic [HASH_W-1:0] t;
    t = h + HASH_W'(b);
    t = t + (t << SH_MIX_L);
    t = t ^ (t >> SH_MIX_R);
    return t;
  endfunction

  // Final avalanche after the last key bit.
  function automatic logic [HASH_W-1:0] hash_final(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + (h << SH_FIN_A);
    t = t ^ (t >> SH_FIN_B);
    t = t + (t << SH_FIN_C);
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/chained_hash_table_engine.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Hash table with separate chaining over a caller-owned pool of node slots.
// ----------------------------------------------------------------------------
// Usage: present a command word (operation, key, node_id) with in_valid; it
// is taken at a clock edge where in_valid is high and in_stall is low.
// in_stall stays high while a command is being worked on, so one command is
// in flight at a time. Every command returns exactly one result word (hit,
// result_node, bucket) on out_valid / out_stall.
// Timing: the key is hashed one bit per cycle, then a finishing step runs
// and the bucket head is read. For each chain node it visits, a lookup or
// delete first reads the key/link memories, then compares the key. The walk
// is capped at NODES nodes.
// Reset (rst, synchronous) clears all bucket head valid bits at once, so
// every chain starts empty; node key and link memories are not cleared.
// When the receiver stalls, the result word is held in the output register;
// a new command is still taken meanwhile and parks in its final state until
// the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chained_hash_table_engine_macros.svh"

module chained_hash_table_engine (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // command channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [cht_pkg::OP_W-1:0]   operation,
  input  wire logic [cht_pkg::KEY_W-1:0]  key,
  input  wire logic [cht_pkg::NID_W-1:0]  node_id,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            hit,
  output logic [cht_pkg::RES_W-1:0]       result_node,
  output logic [cht_pkg::BKT_W-1:0]       bucket
);

  cht_pkg::state_t state, state_next;

  // latched command word
  logic [cht_pkg::OP_W-1:0]   cur_op;
  logic [cht_pkg::KEY_W-1:0]  cur_key;
  logic [cht_pkg::NID_W-1:0]  cur_nid;

  // hash unit
  logic [cht_pkg::HASH_W-1:0] hash;
  logic [cht_pkg::KCNT_W-1:0] kcnt;
  logic [cht_pkg::BKT_W-1:0]  bkt;

  // chain walk
  logic                       walk_valid;
  logic [cht_pkg::NODE_W-1:0] walk_slot;
  logic [cht_pkg::NODE_W-1:0] prev_slot;
  logic                       has_prev;
  logic [cht_pkg::STEP_W-1:0] steps;

  // pending result
  logic                       res_hit;
  logic [cht_pkg::RES_W-1:0]  res_node;

  // memories
  logic [cht_pkg::NODE_W-1:0] head_mem [cht_pkg::BUCKETS];
  logic [cht_pkg::BUCKETS-1:0] head_valid;
  logic [cht_pkg::KEY_W-1:0]  key_mem  [cht_pkg::NODES];
  logic [cht_pkg::LINK_W-1:0] link_mem [cht_pkg::NODES];
  logic [cht_pkg::KEY_W-1:0]  key_rd;
  logic [cht_pkg::LINK_W-1:0] link_rd;

  // write ports
  logic                       head_we;
  logic [cht_pkg::LINK_W-1:0] head_wdata;
  logic                       key_we;
  logic                       link_we;
  logic [cht_pkg::NODE_W-1:0] link_waddr;
  logic [cht_pkg::LINK_W-1:0] link_wdata;

  logic in_take;
  logic out_free;
  logic ins_ok;
  logic key_match;
  logic walk_end;
  logic is_insert;
  logic is_search;

  assign in_stall  = (state != cht_pkg::S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign ins_ok    = (32'(cur_nid) < cht_pkg::NODES);
  assign key_match = (key_rd == cur_key);
  assign walk_end  = !walk_valid || (steps == cht_pkg::STEP_W'(cht_pkg::NODES));
  assign is_insert = (cur_op == cht_pkg::OP_INSERT);
  assign is_search = (cur_op == cht_pkg::OP_LOOKUP) || (cur_op == cht_pkg::OP_DELETE);

  // Sequencer and memory write control.
  always_comb begin
    state_next = state;
    head_we    = 1'b0;
    head_wdata = {1'b1, cht_pkg::NODE_W'(cur_nid)};
    key_we     = 1'b0;
    link_we    = 1'b0;
    link_waddr = cht_pkg::NODE_W'(cur_nid);
    link_wdata = {walk_valid, walk_slot};
    case (state)
      cht_pkg::S_IDLE: begin
        if (in_take) state_next = cht_pkg::S_HASH;
      end
      cht_pkg::S_HASH: begin
        if (kcnt == cht_pkg::KCNT_W'(cht_pkg::KEY_BITS - 1)) state_next = cht_pkg::S_FIN;
      end
      cht_pkg::S_FIN: begin
        // unused codes and out-of-pool inserts report a miss right away
        if ((is_insert && ins_ok) || is_search) state_next = cht_pkg::S_HEAD;
        else state_next = cht_pkg::S_DONE;
      end
      cht_pkg::S_HEAD: begin
        state_next = is_insert ? cht_pkg::S_INS : cht_pkg::S_WALK;
      end
      cht_pkg::S_INS: begin
        // push onto chain head: new node links to the old head
        key_we     = 1'b1;
        link_we    = 1'b1;
        head_we    = 1'b1;
        state_next = cht_pkg::S_DONE;
      end
      cht_pkg::S_WALK: begin
        state_next = walk_end ? cht_pkg::S_DONE : cht_pkg::S_CMP;
      end
      cht_pkg::S_CMP: begin
        if (key_match) begin
          if (cur_op == cht_pkg::OP_DELETE) begin
            // unlink: predecessor or head takes the victim's link
            if (has_prev) begin
              link_we    = 1'b1;
              link_waddr = prev_slot;
              link_wdata = link_rd;
            end else begin
              head_we    = 1'b1;
              head_wdata = link_rd;
            end
          end
          state_next = cht_pkg::S_DONE;
        end else begin
          state_next = cht_pkg::S_WALK;
        end
      end
      cht_pkg::S_DONE: begin
        if (out_free) state_next = cht_pkg::S_IDLE;
      end
      default: state_next = cht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cht_pkg::S_IDLE;
    else state <= state_next;
  end

  // Command latch, hash unit and walk registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_op   <= operation;
      cur_key  <= key;
      cur_nid  <= node_id;
      hash     <= '0;
      kcnt     <= '0;
      res_hit  <= 1'b0;
      res_node <= '0;
    end
    case (state)
      cht_pkg::S_HASH: begin
        hash <= cht_pkg::hash_step(hash, cur_key[kcnt]);
        kcnt <= kcnt + 1'b1;
      end
      cht_pkg::S_FIN: begin
        // bucket count is a power of two: the modulo keeps the low bits
        bkt <= cht_pkg::BKT_W'(cht_pkg::hash_final(hash));
      end
      cht_pkg::S_HEAD: begin
        walk_valid <= head_valid[bkt];
        walk_slot  <= head_mem[bkt];
        has_prev   <= 1'b0;
        steps      <= '0;
      end
      cht_pkg::S_INS: begin
        res_hit  <= 1'b1;
        res_node <= cht_pkg::RES_W'(cur_nid);
      end
      cht_pkg::S_CMP: begin
        if (key_match) begin
          res_hit  <= 1'b1;
          res_node <= cht_pkg::RES_W'(walk_slot);
        end else begin
          // advance to the next node
          prev_slot  <= walk_slot;
          has_prev   <= 1'b1;
          walk_valid <= link_rd[cht_pkg::LINK_W-1];
          walk_slot  <= link_rd[cht_pkg::NODE_W-1:0];
          steps      <= steps + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Memories: one write port each, registered reads.
  always_ff @(posedge clk) begin
    if (head_we) head_mem[bkt] <= head_wdata[cht_pkg::NODE_W-1:0];
    if (key_we) key_mem[cht_pkg::NODE_W'(cur_nid)] <= cur_key;
    if (link_we) link_mem[link_waddr] <= link_wdata;
    key_rd  <= key_mem[walk_slot];
    link_rd <= link_mem[walk_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) head_valid <= '0;
    else if (head_we) head_valid[bkt] <= head_wdata[cht_pkg::LINK_W-1];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == cht_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cht_pkg::S_DONE && out_free) begin
      hit         <= res_hit;
      result_node <= res_node;
      bucket      <= bkt;
    end
  end

  `CHT_ASSERT(a_take_starts_hash, in_take |=> (state == cht_pkg::S_HASH), "take without hashing")
  `CHT_ASSERT(a_step_cap, (state == cht_pkg::S_CMP) |-> !walk_end, "walk went past the node cap")
  `CHT_ASSERT(a_out_from_done, $rose(out_valid) |-> $past(state == cht_pkg::S_DONE), "stray result")
  `CHT_ASSERT(a_insert_sets_head, (state == cht_pkg::S_INS) |=> head_valid[bkt], "empty head")

endmodule

`default_nettype wire

// ===== test/tb_chained_hash_table_engine.sv =====
// ----------------------------------------------------------------------------
// tb_chained_hash_table_engine
// Self-checking bench for the chained hash table engine. A scoreboard keeps
// its own bucket heads, node keys and node links, predicts the result word
// of every accepted command word and compares it field by field. Directed
// words cover empty buckets, chain heads, middles and tails, duplicate keys,
// the unused code and a cyclic chain. Random words then run under phases of
// sender idling and receiver stalling, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_chained_hash_table_engine;
  import cht_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_WORDS    = 150;
  localparam int PRESSURE_WORDS = 100;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic             hit;
    logic [RES_W-1:0] node;
    logic [BKT_W-1:0] bkt;
  } table_result_t;

  // Shadow hash table plus the queue of result words still owed by the block.
  class hash_table_scoreboard;
    logic [LINK_W-1:0] heads     [BUCKETS];
    logic [KEY_W-1:0]  node_key  [NODES];
    logic [LINK_W-1:0] node_next [NODES];
    table_result_t     awaited[$];
    int errors;
    int words_in;
    int words_out;
    int hits;
    int unlinks;
    int capped_walks;

    function new();
      foreach (heads[i]) heads[i] = '0;
      foreach (node_key[i]) begin
        node_key[i]  = '0;
        node_next[i] = '0;
      end
      errors       = 0;
      words_in     = 0;
      words_out    = 0;
      hits         = 0;
      unlinks      = 0;
      capped_walks = 0;
    endfunction

    // One-at-a-time hash, one key bit per round, LSB first.
    function logic [BKT_W-1:0] bucket_of(logic [KEY_W-1:0] k);
      logic [HASH_W-1:0] h;
      h = '0;
      for (int i = 0; i < KEY_BITS; i++) begin
        h = h + HASH_W'(k[i]);
        h = h + (h << SH_MIX_L);
        h = h ^ (h >> SH_MIX_R);
      end
      h = h + (h << SH_FIN_A);
      h = h ^ (h >> SH_FIN_B);
      h = h + (h << SH_FIN_C);
      return BKT_W'(h % BUCKETS);
    endfunction

    // Apply one accepted command word to the shadow table; queue its result.
    function table_result_t note_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                      logic [NID_W-1:0] nid);
      table_result_t     r;
      logic [LINK_W-1:0] cur;
      logic [NODE_W-1:0] slot;
      logic [NODE_W-1:0] prev;
      bit                has_prev;
      int                steps;
      r.bkt    = bucket_of(k);
      r.hit    = 1'b0;
      r.node   = '0;
      prev     = '0;
      has_prev = 1'b0;
      steps    = 0;
      if (op == OP_INSERT) begin
        // an 8-bit node_id always lies inside the pool; push onto the head
        node_key[nid]  = k;
        node_next[nid] = heads[r.bkt];
        heads[r.bkt]   = {1'b1, nid};
        r.hit          = 1'b1;
        r.node         = nid;
      end else if (op == OP_LOOKUP || op == OP_DELETE) begin
        cur = heads[r.bkt];
        while (cur[NODE_W] && steps < NODES && !r.hit) begin
          slot = cur[NODE_W-1:0];
          if (node_key[slot] == k) begin
            r.hit  = 1'b1;
            r.node = slot;
            if (op == OP_DELETE) begin
              unlinks++;
              if (has_prev) node_next[prev] = node_next[slot];
              else heads[r.bkt] = node_next[slot];
            end
          end else begin
            prev     = slot;
            has_prev = 1'b1;
            cur      = node_next[slot];
            steps++;
          end
        end
        if (steps == NODES) capped_walks++;
      end
      if (r.hit) hits++;
      words_in++;
      awaited.push_back(r);
      return r;
    endfunction

    // Compare one accepted result word with the oldest awaited one.
    function void check_word(logic h, logic [RES_W-1:0] n, logic [BKT_W-1:0] b);
      table_result_t e;
      words_out++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: unexpected result word hit=%0d node=%0d bucket=%0d", h, n, b);
        return;
      end
      e = awaited.pop_front();
      if (e.hit !== h || e.node !== n || e.bkt !== b) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: word %0d expected hit=%0d node=%0d bucket=%0d, got %0d/%0d/%0d",
                   words_out, e.hit, e.node, e.bkt, h, n, b);
      end
    endfunction
  endclass

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  operation   = '0;
  logic [KEY_W-1:0] key         = '0;
  logic [NID_W-1:0] node_id     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic             hit;
  logic [RES_W-1:0] result_node;
  logic [BKT_W-1:0] bucket;

  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  bit hold_ack  = 1'b0;

  // Stimulus bookkeeping: which slots the sender believes are in the table.
  bit               slot_live [NODES];
  logic [KEY_W-1:0] slot_key  [NODES];

  hash_table_scoreboard table_sb = new();

  chained_hash_table_engine uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .key         (key),
    .node_id     (node_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .result_node (result_node),
    .bucket      (bucket)
  );

  always #1 clk = ~clk;

  // Result side: random stall, plus one long hold-off on request.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req && !hold_ack) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_ack = 1'b1;
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) table_sb.check_word(hit, result_node, bucket);
  end

  // End the run when neither channel moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Offer one command word, hold it until taken, then update bookkeeping.
  task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                       input logic [NID_W-1:0] nid);
    table_result_t r;
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    node_id   <= nid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = table_sb.note_word(op, k, nid);
    if (op == OP_INSERT) begin
      slot_live[nid] = 1'b1;
      slot_key[nid]  = k;
    end else if (op == OP_DELETE && r.hit) begin
      slot_live[r.node] = 1'b0;
    end
  endtask

  // Pick a slot that is live (or free), scanning from a random start.
  function automatic bit find_slot(input bit want_live, output logic [NID_W-1:0] slot);
    logic [NID_W-1:0] start;
    start = NID_W'($urandom_range(0, NODES - 1));
    slot  = start;
    for (int i = 0; i < NODES; i++) begin
      slot = start + NID_W'(i);
      if (slot_live[slot] == want_live) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Mostly well-formed traffic: inserts into free slots, lookups and deletes
  // of live keys; the rest is noise, stray keys and relinked slots.
  task automatic run_random(input int count);
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] k;
    logic [NID_W-1:0] nid;
    logic [NID_W-1:0] s;
    int               roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      k    = KEY_W'($urandom);
      nid  = NID_W'($urandom);
      if (roll < 4) begin
        op = OP_UNUSED;
      end else if (roll < 8) begin
        op = OP_INSERT;
      end else if (roll < 42) begin
        op = OP_INSERT;
        if (find_slot(1'b0, s)) nid = s;
        if ($urandom_range(0, 3) == 0 && find_slot(1'b1, s)) k = slot_key[s];
      end else begin
        op = (roll < 72) ? OP_LOOKUP : OP_DELETE;
        if ($urandom_range(0, 3) != 0 && find_slot(1'b1, s)) k = slot_key[s];
      end
      issue(op, k, nid);
    end
  endtask

  // Drop valid and wait for every awaited result word.
  task automatic drain();
    in_valid <= 1'b0;
    while (table_sb.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] kb;
    logic [KEY_W-1:0] kc;
    kb = '0;
    kc = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // find two more keys that share key zero's bucket
    for (int cand = 1; cand < 256; cand++) begin
      if (table_sb.bucket_of(KEY_W'(cand)) == table_sb.bucket_of(8'h00)) begin
        if (kb == 0) kb = KEY_W'(cand);
        else if (kc == 0) kc = KEY_W'(cand);
      end
    end

    issue(OP_LOOKUP, 8'h00, 8'h00);   // empty bucket
    issue(OP_DELETE, 8'hFF, 8'hFF);   // delete from empty bucket
    issue(OP_UNUSED, 8'hA5, 8'h5A);
    issue(OP_INSERT, 8'h00, 8'h00);
    issue(OP_INSERT, 8'hFF, 8'hFF);
    issue(OP_LOOKUP, 8'h00, 8'hFF);
    issue(OP_LOOKUP, 8'hFF, 8'h00);
    issue(OP_INSERT, kb, 8'd1);
    issue(OP_INSERT, kc, 8'd2);
    issue(OP_INSERT, 8'h00, 8'd3);    // duplicate key, newest must win
    issue(OP_LOOKUP, 8'h00, 8'h00);
    issue(OP_DELETE, kb, 8'h00);      // unlink from the middle
    issue(OP_LOOKUP, kb, 8'h00);      // miss after walking the chain
    issue(OP_DELETE, 8'h00, 8'h00);   // unlink the head
    issue(OP_LOOKUP, 8'h00, 8'h00);   // older node shows up again
    issue(OP_DELETE, 8'h00, 8'h00);   // unlink the tail
    issue(OP_DELETE, 8'h00, 8'h00);   // nothing left to remove
    issue(OP_UNUSED, 8'hFF, 8'hFF);
    issue(OP_INSERT, 8'h5A, 8'hAA);
    issue(OP_INSERT, 8'hA5, 8'h55);
    issue(OP_INSERT, kc, 8'd2);       // relink a live node onto itself: cycle
    issue(OP_LOOKUP, kc, 8'h00);
    issue(OP_LOOKUP, 8'h00, 8'h00);   // walk the cycle up to the step cap
    issue(OP_DELETE, kb, 8'h00);      // capped walk, table unchanged
    drain();

    idle_pct  = 0;
    stall_pct = 0;
    run_random(PHASE_WORDS);
    drain();

    idle_pct = 75;
    run_random(PHASE_WORDS);
    drain();

    idle_pct  = 0;
    stall_pct = 75;
    run_random(PHASE_WORDS);
    drain();

    idle_pct  = 28;
    stall_pct = 28;
    run_random(PHASE_WORDS);
    drain();

    // hold the result side off while the sender keeps offering words
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    run_random(PRESSURE_WORDS);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d command words, %0d result words, %0d hits, %0d unlinks",
             table_sb.words_in, table_sb.words_out, table_sb.hits, table_sb.unlinks);
    $display("Run: %0d walks hit the step cap; %0d mismatches; idle/stall phases and hold-off",
             table_sb.capped_walks, table_sb.errors);
    if (table_sb.errors == 0 && table_sb.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
